[sv/flh_pkg.sv]
// Shared types, codes and constants of the FNV-1a linear probing table builder.
package flh_pkg;

  localparam logic [1:0] ACT_KEY   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_CLEARED  = 2'd2;
  localparam logic [1:0] ST_READ     = 2'd3;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [3:0] MIN_CAP_LOG2   = 4'd4;
  localparam logic [3:0] RESET_CAP_LOG2 = 4'd12;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  key_byte;
    logic        byte_valid;
    logic        last_byte;
    logic [17:0] entry_id;
    logic [31:0] pool_offset;
    logic [11:0] slot_address;
  } flh_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] slot_index;
    logic [31:0] hash_word;
    logic [17:0] stored_id;
    logic [31:0] stored_offset;
    logic        occupied;
    logic [12:0] probe_count;
  } flh_out_t;

  typedef struct packed {
    logic        used;
    logic [31:0] hash;
    logic [17:0] id;
    logic [31:0] offset;
  } flh_entry_t;

  typedef struct packed {
    logic absorb;
    logic restart;
  } flh_hash_ctl_t;

endpackage

[sv/flh_hash.sv]
// Running FNV-1a hash register with its one-byte fold step.
module flh_hash import flh_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  flh_hash_ctl_t ctl,
  input  logic [7:0]    key_byte,
  output logic [31:0]   hash_upd
);

  logic [31:0] running_r;
  logic [31:0] running_nxt;
  logic [31:0] folded;

  assign folded   = running_r ^ {24'd0, key_byte};
  assign hash_upd = ctl.absorb ? 32'(folded * FNV_PRIME) : running_r;

  always_comb begin
    running_nxt = ctl.restart ? FNV_BASIS : hash_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= FNV_BASIS;
    end else begin
      running_r <= running_nxt;
    end
  end

endmodule

[sv/flh_table.sv]
// Slot memory: one write port and one registered read port.
module flh_table import flh_pkg::*; #(
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  flh_entry_t        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output flh_entry_t        rd_data
);

  flh_entry_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/fnv1a_linear_probe_table_builder.sv]
// Top level: FNV-1a hash table builder with a probing sequencer over one slot memory.
//
// Items enter on in_valid/in_stall and results leave on out_valid/out_stall.
// A key byte that does not end its key is taken and gives no result.
// A key's last byte starts insertion: the home slot is read and checked, then
// each occupied slot costs another read and check in the probe loop, and the
// insert's result is registered once a free slot is found and written.
// A full table gives its result once every slot in the capacity is checked.
// A read of one slot goes through S_RRD, then S_RCHK. A clear writes every
// slot of the memory, one per cycle, and then gives its result.
// The slot memory has one write and one read port, and the probe loop runs
// one slot at a time through it.
// in_stall is high while an item is worked on, so the next item can be taken
// once the result is registered, even while that result still waits.
// After reset the block sweeps the whole memory with in_stall high. cfg writes
// are taken only while the block is idle, and in_stall stays high in any cycle
// where cfg_valid is high.
// When the receiver stalls, the result holds and the next result waits
// inside the block until the output register frees.
module fnv1a_linear_probe_table_builder import flh_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  flh_in_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output flh_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [16:0] DEPTH17 = 17'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PRD   = 3'd2;
  localparam logic [2:0] S_PCHK  = 3'd3;
  localparam logic [2:0] S_RRD   = 3'd4;
  localparam logic [2:0] S_RCHK  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [3:0]    cap_log2_r;
  logic          sweep_emit_r, sweep_emit_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] probes_r, probes_nxt;
  logic [31:0]   key_hash_r, key_hash_nxt;
  logic [17:0]   id_r, id_nxt;
  logic [31:0]   off_r, off_nxt;
  logic [11:0]   raddr_r, raddr_nxt;
  logic          rd_in_range_r, rd_in_range_nxt;
  flh_out_t      pend_r, pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  flh_out_t      out_data_r, out_data_nxt;

  logic          accept;
  flh_hash_ctl_t hash_ctl;
  logic [31:0]   hash_upd;

  logic [3:0]    lg;
  logic [16:0]   cap_raw;
  logic [16:0]   cap17;
  logic [CW-1:0] cap;
  logic [AW-1:0] mask;
  logic [16:0]   addr17;
  logic [CW-1:0] probes_inc;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  flh_entry_t    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  flh_entry_t    rd_data;

  // A capacity write takes the idle cycle, so no item sees it halfway through.
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Capacity in use: at least sixteen slots, never more than the memory holds.
  assign lg      = (cap_log2_r < MIN_CAP_LOG2) ? MIN_CAP_LOG2 : cap_log2_r;
  assign cap_raw = 17'd1 << lg;
  assign cap17   = (cap_raw > DEPTH17) ? DEPTH17 : cap_raw;
  assign cap     = CW'(cap17);
  assign mask    = AW'(cap17 - 17'd1);
  assign addr17  = 17'(in_data.slot_address);
  assign probes_inc = probes_r + CW'(1);

  assign hash_ctl.absorb  = accept && (in_data.action == ACT_KEY) && in_data.byte_valid;
  assign hash_ctl.restart = accept && ((in_data.action == ACT_KEY && in_data.last_byte) ||
                                       in_data.action == ACT_CLEAR);

  flh_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (hash_ctl),
    .key_byte (in_data.key_byte),
    .hash_upd (hash_upd)
  );

  flh_table #(.ADDR_W(AW)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt       = state_r;
    sweep_emit_nxt  = sweep_emit_r;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    probes_nxt      = probes_r;
    key_hash_nxt    = key_hash_r;
    id_nxt          = id_r;
    off_nxt         = off_r;
    raddr_nxt       = raddr_r;
    rd_in_range_nxt = rd_in_range_r;
    pend_nxt        = pend_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;
    wr_en           = 1'b0;
    wr_addr         = cnt_r;
    wr_data         = '0;
    rd_en           = 1'b0;
    rd_addr         = idx_r;

    unique case (state_r)
      S_SWEEP: begin
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST_SLOT) begin
          cnt_nxt = '0;
          if (sweep_emit_r) begin
            pend_nxt        = '0;
            pend_nxt.status = ST_CLEARED;
            state_nxt       = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_data.action)
            ACT_KEY: begin
              if (in_data.last_byte) begin
                key_hash_nxt = hash_upd;
                id_nxt       = in_data.entry_id;
                off_nxt      = in_data.pool_offset;
                idx_nxt      = hash_upd[AW-1:0] & mask;
                probes_nxt   = '0;
                state_nxt    = S_PRD;
              end
            end
            ACT_CLEAR: begin
              sweep_emit_nxt = 1'b1;
              cnt_nxt        = '0;
              state_nxt      = S_SWEEP;
            end
            ACT_READ: begin
              raddr_nxt       = in_data.slot_address;
              rd_in_range_nxt = (addr17 < DEPTH17);
              state_nxt       = S_RRD;
            end
            default: begin
            end
          endcase
        end
      end
      S_PRD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (!rd_data.used) begin
          wr_en          = 1'b1;
          wr_addr        = idx_r;
          wr_data.used   = 1'b1;
          wr_data.hash   = key_hash_r;
          wr_data.id     = id_r;
          wr_data.offset = off_r;
          pend_nxt.status        = ST_INSERTED;
          pend_nxt.slot_index    = 12'(idx_r);
          pend_nxt.hash_word     = key_hash_r;
          pend_nxt.stored_id     = id_r;
          pend_nxt.stored_offset = off_r;
          pend_nxt.occupied      = 1'b1;
          pend_nxt.probe_count   = 13'(probes_r);
          state_nxt              = S_EMIT;
        end else if (probes_inc >= cap) begin
          // Every slot in use: report the home slot and drop the key.
          pend_nxt.status        = ST_FULL;
          pend_nxt.slot_index    = 12'(key_hash_r[AW-1:0] & mask);
          pend_nxt.hash_word     = key_hash_r;
          pend_nxt.stored_id     = '0;
          pend_nxt.stored_offset = '0;
          pend_nxt.occupied      = 1'b0;
          pend_nxt.probe_count   = 13'(cap);
          state_nxt              = S_EMIT;
        end else begin
          probes_nxt = probes_inc;
          idx_nxt    = (idx_r + AW'(1)) & mask;
          state_nxt  = S_PRD;
        end
      end
      S_RRD: begin
        rd_en     = 1'b1;
        rd_addr   = AW'(17'(raddr_r));
        state_nxt = S_RCHK;
      end
      S_RCHK: begin
        pend_nxt            = '0;
        pend_nxt.status     = ST_READ;
        pend_nxt.slot_index = raddr_r;
        if (rd_in_range_r && rd_data.used) begin
          pend_nxt.hash_word     = rd_data.hash;
          pend_nxt.stored_id     = rd_data.id;
          pend_nxt.stored_offset = rd_data.offset;
          pend_nxt.occupied      = 1'b1;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = pend_r;
          sweep_emit_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      sweep_emit_r <= 1'b0;
      cnt_r        <= '0;
      cap_log2_r   <= RESET_CAP_LOG2;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_emit_r <= sweep_emit_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_log2_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    probes_r      <= probes_nxt;
    key_hash_r    <= key_hash_nxt;
    id_r          <= id_nxt;
    off_r         <= off_nxt;
    raddr_r       <= raddr_nxt;
    rd_in_range_r <= rd_in_range_nxt;
    pend_r        <= pend_nxt;
    out_data_r    <= out_data_nxt;
  end

endmodule
